@@ rtl/ple_pkg.sv @@
// shared definitions for the positional list engine
// command and status codes, cell control and sweep types; no dependencies
`default_nettype none

package ple_pkg;

    localparam int DEPTH_DEF = 64;

    localparam logic [2:0] FN_INSERT    = 3'd0;
    localparam logic [2:0] FN_REMOVE    = 3'd1;
    localparam logic [2:0] FN_FIND      = 3'd2;
    localparam logic [2:0] FN_READ      = 3'd3;
    localparam logic [2:0] FN_OVERWRITE = 3'd4;
    localparam logic [2:0] FN_SUM       = 3'd5;
    localparam logic [2:0] FN_APPEND    = 3'd6;
    localparam logic [2:0] FN_SORTED    = 3'd7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic write_en;
        logic find_mode;
    } cell_ctrl_t;

    typedef struct packed {
        logic [31:0] acc;
        logic [31:0] rd;
        logic        found;
    } sweep_t;

endpackage

`default_nettype wire

@@ rtl/ple_cell.sv @@
// one list cell: holds one entry, shifts with its neighbors, passes the sweep on
// depends on ple_pkg
`default_nettype none

module ple_cell #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF,
    parameter int K = 0,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                 clk,
    input  ple_pkg::cell_ctrl_t  ctrl,
    input  logic [AW-1:0]        pos,
    input  logic [CW-1:0]        count,
    input  logic [31:0]          value,
    input  logic [31:0]          left_entry,
    input  logic [31:0]          right_entry,
    output logic [31:0]          entry,
    input  ple_pkg::sweep_t      sweep_in,
    input  logic [AW-1:0]        hit_pos_in,
    output ple_pkg::sweep_t      sweep_out,
    output logic [AW-1:0]        hit_pos_out
);
    import ple_pkg::*;

    localparam logic [AW-1:0] KA = AW'(K);
    localparam logic [CW-1:0] KC = CW'(K);

    logic [31:0]   entry_reg;
    logic [31:0]   entry_next;
    sweep_t        sweep_reg;
    sweep_t        sweep_next;
    logic [AW-1:0] hit_pos_reg;
    logic [AW-1:0] hit_pos_next;
    logic          valid;
    logic          hit;

    assign valid = KC < count;
    assign hit   = valid & (ctrl.find_mode ? (entry_reg == value)
                                           : ($signed(value) <= $signed(entry_reg)));

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift_up && KA > pos)
        begin
            entry_next = left_entry;
        end
        else if ((ctrl.shift_up || ctrl.write_en) && KA == pos)
        begin
            entry_next = value;
        end
        else if (ctrl.shift_down && KA >= pos)
        begin
            entry_next = right_entry;
        end
    end

    always_comb
    begin
        sweep_next.acc   = sweep_in.acc + (valid ? entry_reg : 32'd0);
        sweep_next.rd    = (KA == pos) ? entry_reg : sweep_in.rd;
        sweep_next.found = sweep_in.found | hit;
        hit_pos_next     = sweep_in.found ? hit_pos_in : KA;
    end

    always_ff @(posedge clk)
    begin
        entry_reg   <= entry_next;
        sweep_reg   <= sweep_next;
        hit_pos_reg <= hit_pos_next;
    end

    assign entry       = entry_reg;
    assign sweep_out   = sweep_reg;
    assign hit_pos_out = hit_pos_reg;

endmodule

`default_nettype wire

@@ rtl/positional_list_engine.sv @@
// top level of the positional list engine: command control and the cell chain
// depends on ple_pkg and ple_cell
`default_nettype none

// Bounded ordered list of signed 32-bit entries, one entry per cell in a chain
// of DEPTH cells. Insert, remove, overwrite and append shift or write all cells
// at once in the apply step, which waits for a free output and registers the
// result word. Find, read, sum and sorted insert first run a sweep that moves
// one cell per cycle down the chain and then take the apply step. One command
// is worked on at a time; a new command word is taken while the previous
// result word still waits on the output.

module positional_list_engine #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // func[2:0], index[9:3], value[41:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], data[33:2], position[39:34], count[46:40]
);
    import ple_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;
    logic [2:0]    func_reg;
    logic [6:0]    index_reg;
    logic [31:0]   value_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic [31:0]   data_reg;
    logic [31:0]   data_next;
    logic [5:0]    position_reg;
    logic [5:0]    position_next;

    logic [2:0]    in_func;
    logic          needs_sweep;
    logic          out_free;
    logic          do_apply;
    logic          full;
    logic          idx_gt_count;
    logic          idx_ge_count;
    logic [AW-1:0] cell_pos;
    cell_ctrl_t    ctrl;
    cell_ctrl_t    apply_ctrl;

    logic [31:0]   entry_w   [DEPTH];
    sweep_t        sweep_w   [DEPTH];
    logic [AW-1:0] hit_pos_w [DEPTH];
    sweep_t        last_sweep;
    logic [AW-1:0] last_pos;

    assign in_func     = s_tdata[2:0];
    assign needs_sweep = (in_func == FN_FIND) || (in_func == FN_READ)
                      || (in_func == FN_SUM) || (in_func == FN_SORTED);
    assign out_free    = !out_valid_reg || m_tready;
    assign do_apply    = (state_reg == S_APPLY) && out_free;
    assign full        = count_reg == CW'(DEPTH);
    assign idx_gt_count = 32'(index_reg) > 32'(count_reg);
    assign idx_ge_count = 32'(index_reg) >= 32'(count_reg);
    assign last_sweep  = sweep_w[DEPTH-1];
    assign last_pos    = hit_pos_w[DEPTH-1];

    always_comb
    begin
        case (func_reg)
            FN_APPEND: cell_pos = AW'(count_reg);
            FN_SORTED: cell_pos = last_sweep.found ? last_pos : AW'(count_reg);
            default:   cell_pos = AW'(index_reg);
        endcase
    end

    // result and list update for the command in hand
    always_comb
    begin
        apply_ctrl    = '0;
        status_next   = ST_OK;
        data_next     = 32'd0;
        position_next = 6'd0;
        count_next    = count_reg;
        case (func_reg)
            FN_INSERT:
            begin
                if (idx_gt_count)
                begin
                    status_next = ST_RANGE;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    apply_ctrl.shift_up = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            FN_REMOVE:
            begin
                if (idx_ge_count)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    apply_ctrl.shift_down = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            FN_FIND:
            begin
                if (last_sweep.found)
                begin
                    position_next = 6'(last_pos);
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                end
            end
            FN_READ:
            begin
                if (idx_ge_count)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    data_next = last_sweep.rd;
                end
            end
            FN_OVERWRITE:
            begin
                if (idx_ge_count)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    apply_ctrl.write_en = 1'b1;
                end
            end
            FN_SUM:
            begin
                data_next = last_sweep.acc;
            end
            FN_APPEND, FN_SORTED:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    apply_ctrl.shift_up = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        ctrl            = do_apply ? apply_ctrl : '0;
        ctrl.find_mode  = func_reg == FN_FIND;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (s_tvalid)
                begin
                    state_next = needs_sweep ? S_SWEEP : S_APPLY;
                end
            end
            S_SWEEP:
            begin
                if (cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_APPLY;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (do_apply)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            func_reg  <= s_tdata[2:0];
            index_reg <= s_tdata[9:3];
            value_reg <= s_tdata[41:10];
        end
        if (do_apply)
        begin
            status_reg   <= status_next;
            data_reg     <= data_next;
            position_reg <= position_next;
        end
    end

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            logic [31:0]   left_entry;
            logic [31:0]   right_entry;
            sweep_t        sweep_in;
            logic [AW-1:0] hit_pos_in;

            if (k == 0)
            begin : g_first
                assign left_entry = 32'd0;
                assign sweep_in   = '0;
                assign hit_pos_in = '0;
            end
            else
            begin : g_inner
                assign left_entry = entry_w[k-1];
                assign sweep_in   = sweep_w[k-1];
                assign hit_pos_in = hit_pos_w[k-1];
            end

            if (k == DEPTH - 1)
            begin : g_last
                assign right_entry = 32'd0;
            end
            else
            begin : g_body
                assign right_entry = entry_w[k+1];
            end

            ple_cell #(
                .DEPTH (DEPTH),
                .K     (k)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .pos         (cell_pos),
                .count       (count_reg),
                .value       (value_reg),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (entry_w[k]),
                .sweep_in    (sweep_in),
                .hit_pos_in  (hit_pos_in),
                .sweep_out   (sweep_w[k]),
                .hit_pos_out (hit_pos_w[k])
            );
        end
    endgenerate

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, 7'(count_reg), position_reg, data_reg, status_reg};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(DEPTH))
        else $error("entry count beyond depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CW'(1) || count_reg == $past(count_reg) - CW'(1)))
        else $error("entry count moved by more than one");

    a_result_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == S_APPLY)
        else $error("result word without a finished command");

    a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.shift_up && ctrl.shift_down))
        else $error("chain shifted both ways");
`endif

endmodule

`default_nettype wire
